FILE: hw/rtl/gte_pkg.sv
// Shared types, constants and helpers for the GeneralizedTime to epoch converter.
// Used by gte_ctrl, gte_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package gte_pkg;

  localparam int unsigned EPOCH_W = 39;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned LEN_W   = 4;

  localparam logic [LEN_W-1:0]   LEN_MIN    = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
  localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
  localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
  localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
  localparam logic [FIELD_W-1:0] SECOND_MAX = 7'd60;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND,
    FLD_OFF_H,
    FLD_OFF_M
  } field_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_RANGE,
    STEP_YEAR,
    STEP_DOE,
    STEP_DAYS,
    STEP_SECS,
    STEP_OUT
  } conv_step_t;

  // controller -> datapath
  typedef struct packed {
    logic       acc_en;
    field_t     acc_sel;
    logic       acc_load;   // start field from this digit instead of acc*10+d
    logic       sign_en;
    logic       sign_neg;
    logic       clear;
    conv_step_t step;
    logic       fmt_ok;
  } gte_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_zulu;
    logic is_plus;
    logic is_minus;
    logic out_free;
  } gte_sts_t;

  function automatic logic [YEAR_W-1:0] mul10_add(logic [YEAR_W-1:0] a, logic [3:0] d);
    return (a << 3) + (a << 1) + {{(YEAR_W-4){1'b0}}, d};
  endfunction

  // day of year counted from March 1st for the first day of a month
  function automatic logic [8:0] march_doy(logic [FIELD_W-1:0] month);
    logic [8:0] doy;
    doy = 9'd0;
    unique case (month)
      7'd3:    doy = 9'd0;
      7'd4:    doy = 9'd31;
      7'd5:    doy = 9'd61;
      7'd6:    doy = 9'd92;
      7'd7:    doy = 9'd122;
      7'd8:    doy = 9'd153;
      7'd9:    doy = 9'd184;
      7'd10:   doy = 9'd214;
      7'd11:   doy = 9'd245;
      7'd12:   doy = 9'd275;
      7'd1:    doy = 9'd306;
      7'd2:    doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

FILE: hw/rtl/generalized_time_to_epoch.sv
// Throughput: one character per cycle while parsing; after the last character the input
// is held off for the 6-step calendar conversion, and longer while a finished result
// waits on out_tready; the result is registered in the last of those steps.
// Reset: synchronous, active low; clears the parser, the field accumulators and out_tvalid.
// Top level: instantiates gte_ctrl and gte_datapath; depends on gte_pkg.
`timescale 1ns / 1ps

module generalized_time_to_epoch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [38:0] epoch_seconds, [39] zero pad
  output logic        out_tuser   // [0] time_valid
);
  import gte_pkg::*;

  gte_cmd_t           cmd;
  gte_sts_t           sts;
  logic               in_fire;
  logic [EPOCH_W-1:0] epoch;

  assign in_fire = in_tvalid && in_tready;

  gte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_tlast),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  gte_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_epoch (epoch),
    .out_ok    (out_tuser)
  );

  assign out_tdata = {1'b0, epoch};

endmodule

FILE: hw/rtl/gte_ctrl.sv
// Parser and conversion sequencer for the GeneralizedTime converter.
// Depends on gte_pkg; drives gte_datapath through gte_cmd_t.
`timescale 1ns / 1ps

module gte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  gte_pkg::gte_sts_t sts,
  output gte_pkg::gte_cmd_t cmd,
  output logic              in_tready
);
  import gte_pkg::*;

  // parse states come first; everything from S_CV_RANGE on blocks input
  typedef enum logic [4:0] {
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MINUTE,
    S_AFTER_MIN,
    S_SECOND,
    S_AFTER_SEC,
    S_FRACTION,
    S_OFF_H,
    S_AFTER_OFFH,
    S_OFF_M,
    S_DONE,
    S_CV_RANGE,
    S_CV_YEAR,
    S_CV_DOE,
    S_CV_DAYS,
    S_CV_SECS,
    S_CV_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             failed_r, failed_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             fmt_ok_r, fmt_ok_nxt;
  logic             in_tready_r;

  logic             dig_phase;
  field_t           dig_fld;
  logic [1:0]       dig_last;
  state_t           dig_next;
  state_t           zone_next;
  logic             zone_fail;

  // fixed-length digit fields
  always_comb begin
    dig_phase = 1'b1;
    dig_fld   = FLD_YEAR;
    dig_last  = 2'd1;
    dig_next  = S_DONE;
    unique case (state_r)
      S_YEAR:   begin dig_fld = FLD_YEAR;   dig_last = 2'd3; dig_next = S_MONTH;      end
      S_MONTH:  begin dig_fld = FLD_MONTH;  dig_next = S_DAY;                         end
      S_DAY:    begin dig_fld = FLD_DAY;    dig_next = S_HOUR;                        end
      S_HOUR:   begin dig_fld = FLD_HOUR;   dig_next = S_MINUTE;                      end
      S_MINUTE: begin dig_fld = FLD_MINUTE; dig_next = S_AFTER_MIN;                   end
      S_SECOND: begin dig_fld = FLD_SECOND; dig_next = S_AFTER_SEC;                   end
      S_OFF_H:  begin dig_fld = FLD_OFF_H;  dig_next = S_AFTER_OFFH;                  end
      S_OFF_M:  begin dig_fld = FLD_OFF_M;  dig_next = S_DONE;                        end
      default:  dig_phase = 1'b0;
    endcase
  end

  // start of the zone designator
  always_comb begin
    zone_fail = 1'b0;
    zone_next = state_r;
    priority if (sts.is_zulu) begin
      zone_next = S_DONE;
    end else if (sts.is_plus || sts.is_minus) begin
      zone_next = S_OFF_H;
    end else begin
      zone_fail = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    failed_nxt = failed_r;
    len_nxt    = len_r;
    fmt_ok_nxt = fmt_ok_r;
    cmd        = '0;
    cmd.acc_sel = dig_fld;
    cmd.fmt_ok  = fmt_ok_r;

    if (in_fire) begin
      if (len_r < LEN_MIN) len_nxt = len_r + 4'd1;
      if (!failed_r) begin
        if (dig_phase) begin
          if (!sts.is_digit) begin
            failed_nxt = 1'b1;
          end else begin
            cmd.acc_en = 1'b1;
            if (idx_r == dig_last) begin
              idx_nxt   = 2'd0;
              state_nxt = dig_next;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end else begin
          unique case (state_r)
            S_AFTER_MIN: begin
              priority if (sts.is_digit) begin
                cmd.acc_en   = 1'b1;
                cmd.acc_sel  = FLD_SECOND;
                cmd.acc_load = 1'b1;
                idx_nxt      = 2'd1;
                state_nxt    = S_SECOND;
              end else if (sts.is_dot) begin
                state_nxt = S_FRACTION;
              end else begin
                state_nxt    = zone_next;
                failed_nxt   = zone_fail;
                cmd.sign_en  = sts.is_plus || sts.is_minus;
                cmd.sign_neg = sts.is_minus;
              end
            end
            S_AFTER_SEC: begin
              if (sts.is_dot) begin
                state_nxt = S_FRACTION;
              end else begin
                state_nxt    = zone_next;
                failed_nxt   = zone_fail;
                cmd.sign_en  = sts.is_plus || sts.is_minus;
                cmd.sign_neg = sts.is_minus;
              end
            end
            S_FRACTION: begin
              if (!sts.is_digit) begin
                state_nxt    = zone_next;
                failed_nxt   = zone_fail;
                cmd.sign_en  = sts.is_plus || sts.is_minus;
                cmd.sign_neg = sts.is_minus;
              end
            end
            S_AFTER_OFFH: begin
              if (sts.is_digit) begin
                cmd.acc_en   = 1'b1;
                cmd.acc_sel  = FLD_OFF_M;
                cmd.acc_load = 1'b1;
                idx_nxt      = 2'd1;
                state_nxt    = S_OFF_M;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      if (in_last) begin
        fmt_ok_nxt = !failed_nxt && (len_nxt >= LEN_MIN) &&
                     (state_nxt == S_AFTER_MIN || state_nxt == S_AFTER_SEC ||
                      state_nxt == S_FRACTION || state_nxt == S_AFTER_OFFH ||
                      state_nxt == S_DONE);
        state_nxt  = S_CV_RANGE;
        idx_nxt    = 2'd0;
        failed_nxt = 1'b0;
        len_nxt    = '0;
      end
    end else begin
      unique case (state_r)
        S_CV_RANGE: begin cmd.step = STEP_RANGE; state_nxt = S_CV_YEAR; end
        S_CV_YEAR:  begin cmd.step = STEP_YEAR;  state_nxt = S_CV_DOE;  end
        S_CV_DOE:   begin cmd.step = STEP_DOE;   state_nxt = S_CV_DAYS; end
        S_CV_DAYS:  begin cmd.step = STEP_DAYS;  state_nxt = S_CV_SECS; end
        S_CV_SECS:  begin cmd.step = STEP_SECS;  state_nxt = S_CV_OUT;  end
        S_CV_OUT: begin
          if (sts.out_free) begin
            cmd.step  = STEP_OUT;
            cmd.clear = 1'b1;
            state_nxt = S_YEAR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_YEAR;
      idx_r       <= 2'd0;
      failed_r    <= 1'b0;
      len_r       <= '0;
      fmt_ok_r    <= 1'b0;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      failed_r    <= failed_nxt;
      len_r       <= len_nxt;
      fmt_ok_r    <= fmt_ok_nxt;
      in_tready_r <= (state_nxt < S_CV_RANGE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

FILE: hw/rtl/gte_datapath.sv
// Field accumulators, calendar arithmetic and output register.
// Depends on gte_pkg; sequenced by gte_ctrl through gte_cmd_t.
`timescale 1ns / 1ps

module gte_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_char,
  input  gte_pkg::gte_cmd_t            cmd,
  output gte_pkg::gte_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gte_pkg::EPOCH_W-1:0]  out_epoch,
  output logic                         out_ok
);
  import gte_pkg::*;

  localparam logic [12:0] EraRecip  = 13'd5243;   // 2^21 / 400, rounded up
  localparam int unsigned EraShift  = 21;
  localparam logic [23:0] DaysShift = 24'd719468;  // 0000-03-01 to 1970-01-01

  function automatic logic [FIELD_W-1:0] next_field(logic [FIELD_W-1:0] a, logic load,
                                                   logic [3:0] d);
    logic [YEAR_W-1:0] acc;
    acc = mul10_add({{(YEAR_W-FIELD_W){1'b0}}, a}, d);
    return load ? {{(FIELD_W-4){1'b0}}, d} : acc[FIELD_W-1:0];
  endfunction

  logic [YEAR_W-1:0]  year_r;
  logic [FIELD_W-1:0] month_r, day_r, hour_r, minute_r, second_r, off_h_r, off_m_r;
  logic               neg_r;

  logic               ok_r;
  logic [YEAR_W-1:0]  yy_r;
  logic [4:0]         era_r;
  logic [8:0]         doy_r;
  logic [8:0]         yoe_r;
  logic [17:0]        doe_r;
  logic [21:0]        days_r;
  logic [18:0]        off_r;
  logic [37:0]        secs_r;

  logic               out_valid_r;
  logic [EPOCH_W-1:0] out_epoch_r;
  logic               out_ok_r;

  logic [3:0]         dval;
  logic [YEAR_W-1:0]  yy_c;
  logic [26:0]        era_prod;
  logic               range_ok;
  logic [YEAR_W-1:0]  era400;
  logic [YEAR_W-1:0]  yoe_c;
  logic [17:0]        yoe365;
  logic [14:0]        yoe41;
  logic [17:0]        doe_c;
  logic [23:0]        era_days;
  logic [23:0]        days_c;
  logic [18:0]        off_c;
  logic [EPOCH_W-1:0] day_secs;
  logic [18:0]        hms_c;
  logic [EPOCH_W-1:0] secs_c;
  logic [EPOCH_W-1:0] epoch_c;

  assign dval = in_char[3:0];

  assign sts.is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign sts.is_dot   = (in_char == CH_DOT);
  assign sts.is_zulu  = (in_char == CH_UPZ) || (in_char == CH_LOWZ);
  assign sts.is_plus  = (in_char == CH_PLUS);
  assign sts.is_minus = (in_char == CH_MINUS);
  assign sts.out_free = !out_valid_r || out_ready;

  // era = floor(yy / 400) by reciprocal; exact for yy below 10000
  assign yy_c     = (month_r <= 7'd2) ? year_r - 14'd1 : year_r;
  assign era_prod = 27'(yy_c) * 27'(EraRecip);
  assign range_ok = cmd.fmt_ok &&
                    (year_r >= YEAR_MIN) && (year_r <= YEAR_MAX) &&
                    (month_r >= 7'd1) && (month_r <= MONTH_MAX) &&
                    (day_r >= 7'd1) && (day_r <= DAY_MAX) &&
                    (hour_r <= HOUR_MAX) && (minute_r <= MINUTE_MAX) &&
                    (second_r <= SECOND_MAX);

  assign era400 = YEAR_W'(era_r) * 14'd400;
  assign yoe_c  = yy_r - era400;

  // yoe/100 as (yoe*41)>>12, exact for yoe below 400
  assign yoe365 = 18'(yoe_r) * 18'd365;
  assign yoe41  = 15'(yoe_r) * 15'd41;
  assign doe_c  = yoe365 + 18'(yoe_r[8:2]) - 18'(yoe41[13:12]) + 18'(doy_r) +
                  18'(day_r) - 18'd1;

  assign era_days = 24'(era_r) * 24'd146097;
  assign days_c   = era_days + 24'(doe_r) - DaysShift;
  assign off_c    = 19'(off_h_r) * 19'd3600 + 19'(off_m_r) * 19'd60;

  assign day_secs = EPOCH_W'(days_r) * 39'd86400;
  assign hms_c    = 19'(hour_r) * 19'd3600 + 19'(minute_r) * 19'd60 + 19'(second_r);
  assign secs_c   = day_secs + EPOCH_W'(hms_c);

  assign epoch_c = neg_r ? {1'b0, secs_r} + EPOCH_W'(off_r)
                         : {1'b0, secs_r} - EPOCH_W'(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      off_h_r  <= '0;
      off_m_r  <= '0;
      neg_r    <= 1'b0;
    end else if (cmd.clear) begin
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      off_h_r  <= '0;
      off_m_r  <= '0;
      neg_r    <= 1'b0;
    end else begin
      if (cmd.sign_en) neg_r <= cmd.sign_neg;
      if (cmd.acc_en) begin
        unique case (cmd.acc_sel)
          FLD_YEAR:   year_r   <= mul10_add(year_r, dval);
          FLD_MONTH:  month_r  <= next_field(month_r, cmd.acc_load, dval);
          FLD_DAY:    day_r    <= next_field(day_r, cmd.acc_load, dval);
          FLD_HOUR:   hour_r   <= next_field(hour_r, cmd.acc_load, dval);
          FLD_MINUTE: minute_r <= next_field(minute_r, cmd.acc_load, dval);
          FLD_SECOND: second_r <= next_field(second_r, cmd.acc_load, dval);
          FLD_OFF_H:  off_h_r  <= next_field(off_h_r, cmd.acc_load, dval);
          FLD_OFF_M:  off_m_r  <= next_field(off_m_r, cmd.acc_load, dval);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_RANGE: begin
        ok_r  <= range_ok;
        yy_r  <= yy_c;
        era_r <= era_prod[EraShift+4:EraShift];
        doy_r <= march_doy(month_r);
      end
      STEP_YEAR: yoe_r  <= yoe_c[8:0];
      STEP_DOE:  doe_r  <= doe_c;
      STEP_DAYS: begin
        days_r <= days_c[21:0];
        off_r  <= off_c;
      end
      STEP_SECS: secs_r <= secs_c[37:0];
      STEP_OUT: begin
        out_epoch_r <= ok_r ? epoch_c : '0;
        out_ok_r    <= ok_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step == STEP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_epoch = out_epoch_r;
  assign out_ok    = out_ok_r;

endmodule

FILE: hw/rtl/gte_checker.sv
// Port-level checks for generalized_time_to_epoch, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module gte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // a result waiting on the sink holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a rejected string reports zero seconds
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("invalid result with nonzero seconds");

  // input is held off through the first conversion steps after the last character
  a_conv_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input accepted during conversion");

  // zero pad above the 39-bit field stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39] == 1'b0)
    else $error("tdata pad bit set");

endmodule

bind generalized_time_to_epoch gte_checker u_gte_checker (.*);
